FILE: design/lfl_pkg.sv
// Shared types, constants and register map for the line follow / lift controller.
`timescale 1ns / 1ps

package lfl_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int LANE_SAMPLES = 4;
  localparam int GROUP_BITS   = SAMPLE_BITS * LANE_SAMPLES;
  localparam int SUM_BITS     = SAMPLE_BITS + $clog2(LANE_SAMPLES);
  localparam int AVG_SHIFT    = $clog2(LANE_SAMPLES);
  localparam int BASE_BITS    = 10;
  localparam int DUTY_BITS    = 8;
  localparam int MAGNET_BITS  = 12;
  localparam int RANGE_BITS   = 16;
  localparam int WAIT_BITS    = 4;
  localparam int TICK_BITS    = 5;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [DUTY_BITS-1:0] DUTY_FULL = '1;
  localparam logic [DUTY_BITS-1:0] DUTY_OFF  = '0;

  localparam logic [BASE_BITS-1:0]   APPROACH_BASE_RST    = 10'd270;
  localparam logic [BASE_BITS-1:0]   FOLLOW_BASE_RST      = 10'd260;
  localparam logic [MAGNET_BITS-1:0] MAGNET_THRESHOLD_RST = 12'd100;
  localparam logic [RANGE_BITS-1:0]  RANGE_MIN_RST        = 16'd20;
  localparam logic [RANGE_BITS-1:0]  RANGE_MAX_RST        = 16'd500;
  localparam logic [WAIT_BITS-1:0]   ECHO_WAIT_RST        = 4'd3;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_APPROACH = 3'd1,
    MODE_LIFT     = 3'd2,
    MODE_WAIT     = 3'd3,
    MODE_FOLLOW   = 3'd4
  } lfl_mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_APPROACH_BASE    = 3'd0,
    REG_FOLLOW_BASE      = 3'd1,
    REG_MAGNET_THRESHOLD = 3'd2,
    REG_RANGE_MIN        = 3'd3,
    REG_RANGE_MAX        = 3'd4,
    REG_ECHO_WAIT        = 3'd5
  } lfl_reg_t;

  typedef struct packed {
    logic [BASE_BITS-1:0]   approach_base;
    logic [BASE_BITS-1:0]   follow_base;
    logic [MAGNET_BITS-1:0] magnet_threshold;
    logic [RANGE_BITS-1:0]  range_min;
    logic [RANGE_BITS-1:0]  range_max;
    logic [WAIT_BITS-1:0]   echo_wait;
  } lfl_cfg_t;

  typedef struct packed {
    logic [GROUP_BITS-1:0]  left_samples;
    logic [GROUP_BITS-1:0]  right_samples;
    logic [MAGNET_BITS-1:0] magnet_level;
    logic                   button_event;
    logic                   lift_reed_event;
    logic                   return_reed_event;
    logic [RANGE_BITS-1:0]  range_reading;
  } lfl_in_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0]  left_duty;
    logic [DUTY_BITS-1:0]  right_duty;
    logic [DUTY_BITS-1:0]  lift_up_duty;
    logic [DUTY_BITS-1:0]  lift_down_duty;
    logic                  indicator;
    logic [2:0]            mode_now;
    logic                  ping_request;
    logic                  range_valid;
    logic [RANGE_BITS-1:0] range_out;
  } lfl_out_t;

  typedef struct packed {
    lfl_mode_t            mode;
    logic [BASE_BITS-1:0] wheel_base;
  } lfl_status_t;

endpackage

FILE: design/lfl_stream_if.sv
// Valid/ready channel interfaces for sensor beats and result beats.
`timescale 1ns / 1ps

interface lfl_in_if;
  import lfl_pkg::*;
  logic    valid;
  logic    ready;
  lfl_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface lfl_out_if;
  import lfl_pkg::*;
  logic     valid;
  logic     ready;
  lfl_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/line_follow_lift_mode_controller.sv
// Top level: config registers, two wheel lanes, mode merge stage and result register.
//
//  channel  dir  handshake            payload
//  sensor   in   valid/ready          lfl_in_t  (samples, magnet, events, range)
//  result   out  valid/ready          lfl_out_t (duties, led, mode, ping, range)
//  cfg      in   cfg_we, no stall     cfg_index, cfg_data
//
// One sensor beat per cycle while the result register is empty or being drained; its result is registered and
// appears in the cycle after acceptance, held in the single result register after the mode merge stage.
// A new beat is taken while the held result is being taken by the sink.
// rst (synchronous) clears mode state, flags, levels and the result valid, and reloads the config reset values.
`timescale 1ns / 1ps

module line_follow_lift_mode_controller
  import lfl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  lfl_in_if.sink                   sensor,
  lfl_out_if.source                result,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  lfl_cfg_t             cfg;
  lfl_status_t          status;
  lfl_out_t             merged;
  lfl_out_t             res_q;
  logic                 res_valid;
  logic                 fire;
  logic [DUTY_BITS-1:0] left_duty, right_duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.approach_base    <= APPROACH_BASE_RST;
      cfg.follow_base      <= FOLLOW_BASE_RST;
      cfg.magnet_threshold <= MAGNET_THRESHOLD_RST;
      cfg.range_min        <= RANGE_MIN_RST;
      cfg.range_max        <= RANGE_MAX_RST;
      cfg.echo_wait        <= ECHO_WAIT_RST;
    end else if (cfg_we) begin
      case (lfl_reg_t'(cfg_index))
        REG_APPROACH_BASE:    cfg.approach_base    <= cfg_data[BASE_BITS-1:0];
        REG_FOLLOW_BASE:      cfg.follow_base      <= cfg_data[BASE_BITS-1:0];
        REG_MAGNET_THRESHOLD: cfg.magnet_threshold <= cfg_data[MAGNET_BITS-1:0];
        REG_RANGE_MIN:        cfg.range_min        <= cfg_data[RANGE_BITS-1:0];
        REG_RANGE_MAX:        cfg.range_max        <= cfg_data[RANGE_BITS-1:0];
        REG_ECHO_WAIT:        cfg.echo_wait        <= cfg_data[WAIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign sensor.ready = !res_valid || result.ready;
  assign fire         = sensor.valid && sensor.ready;

  lfl_lane u_lane_left (
    .base    (status.wheel_base),
    .samples (sensor.payload.left_samples),
    .duty    (left_duty)
  );

  lfl_lane u_lane_right (
    .base    (status.wheel_base),
    .samples (sensor.payload.right_samples),
    .duty    (right_duty)
  );

  lfl_mode_ctrl u_mode (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .item            (sensor.payload),
    .cfg             (cfg),
    .lane_left_duty  (left_duty),
    .lane_right_duty (right_duty),
    .status          (status),
    .result          (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= merged;
    end
  end

  assign result.valid   = res_valid;
  assign result.payload = res_q;

  a_range_in_limits: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_q.range_valid |->
      res_q.range_out >= cfg.range_min && res_q.range_out <= cfg.range_max)
    else $error("reported range outside limits");

  a_lift_wheels_off: assert property (@(posedge clk) disable iff (rst)
    fire && status.mode == MODE_LIFT |=>
      res_q.left_duty == DUTY_OFF && res_q.right_duty == DUTY_OFF &&
      res_q.lift_up_duty == DUTY_FULL)
    else $error("lift beat did not stop wheels and raise");

  a_ping_from_follow: assert property (@(posedge clk) disable iff (rst)
    fire && status.mode != MODE_FOLLOW |=> !res_q.ping_request && !res_q.range_valid)
    else $error("ping or range outside follow mode");

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

FILE: design/lfl_lane.sv
// One wheel lane: base minus the average of four line samples, low byte.
`timescale 1ns / 1ps

module lfl_lane
  import lfl_pkg::*;
(
  input  logic [BASE_BITS-1:0]  base,
  input  logic [GROUP_BITS-1:0] samples,
  output logic [DUTY_BITS-1:0]  duty
);

  logic [SUM_BITS-1:0]    sum;
  logic [SAMPLE_BITS-1:0] avg;

  always_comb begin
    sum = '0;
    for (int k = 0; k < LANE_SAMPLES; k++) begin
      sum = sum + SUM_BITS'(samples[k*SAMPLE_BITS +: SAMPLE_BITS]);
    end
  end

  assign avg  = SAMPLE_BITS'(sum >> AVG_SHIFT);
  assign duty = base[DUTY_BITS-1:0] - avg[DUTY_BITS-1:0];

endmodule

FILE: design/lfl_mode_ctrl.sv
// Mode machine and merge stage: combines lane duties with lift, led and range logic.
`timescale 1ns / 1ps

module lfl_mode_ctrl
  import lfl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  lfl_in_t              item,
  input  lfl_cfg_t             cfg,
  input  logic [DUTY_BITS-1:0] lane_left_duty,
  input  logic [DUTY_BITS-1:0] lane_right_duty,
  output lfl_status_t          status,
  output lfl_out_t             result
);

  lfl_mode_t             mode, mode_next;
  logic                  button_pending, button_pending_next;
  logic                  lift_done_flag, lift_done_flag_next;
  logic                  return_done_flag, return_done_flag_next;
  logic                  ping_outstanding, ping_outstanding_next;
  logic [TICK_BITS-1:0]  echo_ticks, echo_ticks_next;
  logic [DUTY_BITS-1:0]  raise_level, raise_level_next;
  logic [DUTY_BITS-1:0]  lower_level, lower_level_next;
  logic                  led_level, led_level_next;

  logic btn_seen, lift_seen, return_seen, due, in_limits;

  assign btn_seen  = button_pending | item.button_event;
  assign due       = (echo_ticks == TICK_BITS'(cfg.echo_wait));
  assign in_limits = (item.range_reading >= cfg.range_min) &&
                     (item.range_reading <= cfg.range_max);

  always_comb begin
    lift_seen   = lift_done_flag;
    return_seen = return_done_flag;
    if (mode == MODE_LIFT && item.lift_reed_event) begin
      lift_seen   = 1'b1;
      return_seen = 1'b0;
    end
    if (mode == MODE_WAIT && item.return_reed_event) begin
      lift_seen   = 1'b0;
      return_seen = 1'b1;
    end
  end

  always_comb begin
    mode_next             = mode;
    button_pending_next   = btn_seen;
    lift_done_flag_next   = lift_seen;
    return_done_flag_next = return_seen;
    ping_outstanding_next = ping_outstanding;
    echo_ticks_next       = echo_ticks;
    raise_level_next      = raise_level;
    lower_level_next      = lower_level;
    led_level_next        = led_level;
    unique case (mode)
      MODE_APPROACH: begin
        if (item.magnet_level >= cfg.magnet_threshold) begin
          mode_next = MODE_LIFT;
        end
        if (btn_seen) begin
          button_pending_next = 1'b0;
          mode_next           = MODE_IDLE;
        end
        led_level_next = 1'b0;
      end
      MODE_LIFT: begin
        raise_level_next = DUTY_FULL;
        lower_level_next = DUTY_OFF;
        if (lift_seen) begin
          mode_next = MODE_WAIT;
        end
        led_level_next = 1'b1;
      end
      MODE_WAIT: begin
        raise_level_next = DUTY_OFF;
        lower_level_next = DUTY_FULL;
        if (return_seen) begin
          lower_level_next = DUTY_OFF;
          mode_next        = MODE_FOLLOW;
        end
      end
      MODE_FOLLOW: begin
        led_level_next        = 1'b0;
        ping_outstanding_next = 1'b1;
        if (ping_outstanding) begin
          echo_ticks_next = echo_ticks + 1'b1;
        end
        if (due) begin
          ping_outstanding_next = 1'b0;
          echo_ticks_next       = '0;
        end
        if (btn_seen) begin
          button_pending_next = 1'b0;
          mode_next           = MODE_IDLE;
        end
      end
      default: begin
        led_level_next      = 1'b1;
        mode_next           = btn_seen ? MODE_APPROACH : MODE_IDLE;
        button_pending_next = 1'b0;
      end
    endcase
  end

  always_comb begin
    result                = '0;
    result.lift_up_duty   = raise_level_next;
    result.lift_down_duty = lower_level_next;
    result.indicator      = led_level_next;
    result.mode_now       = mode_next;
    unique case (mode)
      MODE_APPROACH: begin
        result.left_duty  = lane_left_duty;
        result.right_duty = lane_right_duty;
      end
      MODE_FOLLOW: begin
        result.left_duty    = lane_left_duty;
        result.right_duty   = lane_right_duty;
        result.ping_request = !ping_outstanding;
        result.range_valid  = due && in_limits;
        result.range_out    = (due && in_limits) ? item.range_reading : '0;
      end
      default: begin
        result.left_duty  = DUTY_OFF;
        result.right_duty = DUTY_OFF;
      end
    endcase
  end

  assign status.mode       = mode;
  assign status.wheel_base = (mode == MODE_FOLLOW) ? cfg.follow_base : cfg.approach_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_IDLE;
      button_pending   <= 1'b0;
      lift_done_flag   <= 1'b0;
      return_done_flag <= 1'b0;
      ping_outstanding <= 1'b0;
      echo_ticks       <= '0;
      raise_level      <= '0;
      lower_level      <= '0;
      led_level        <= 1'b0;
    end else if (fire) begin
      mode             <= mode_next;
      button_pending   <= button_pending_next;
      lift_done_flag   <= lift_done_flag_next;
      return_done_flag <= return_done_flag_next;
      ping_outstanding <= ping_outstanding_next;
      echo_ticks       <= echo_ticks_next;
      raise_level      <= raise_level_next;
      lower_level      <= lower_level_next;
      led_level        <= led_level_next;
    end
  end

endmodule

FILE: tb/tb_line_follow_lift_mode_controller.sv
// Self-checking testbench for the line follow / lift mode controller.
`timescale 1ns / 1ps

module tb_line_follow_lift_mode_controller;
  import lfl_pkg::*;

  localparam int STALL_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  lfl_in_if sensor_if ();
  lfl_out_if result_if ();

  line_follow_lift_mode_controller u_dut (
    .clk(clk),
    .rst(rst),
    .sensor(sensor_if),
    .result(result_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // controller model state
  lfl_cfg_t regs;
  lfl_mode_t ctl_mode;
  logic btn_pend, lift_flag, ret_flag, ping_out, led;
  logic [TICK_BITS-1:0] echo_cnt;
  logic [DUTY_BITS-1:0] raise_lvl, lower_lvl, wheel_l, wheel_r;

  lfl_out_t expected_beats[$];
  lfl_out_t want_beat;
  int unsigned mismatches = 0;
  bit bursts_on = 1'b1;

  function automatic void reset_controller_model();
    regs.approach_base    = APPROACH_BASE_RST;
    regs.follow_base      = FOLLOW_BASE_RST;
    regs.magnet_threshold = MAGNET_THRESHOLD_RST;
    regs.range_min        = RANGE_MIN_RST;
    regs.range_max        = RANGE_MAX_RST;
    regs.echo_wait        = ECHO_WAIT_RST;
    ctl_mode  = MODE_IDLE;
    btn_pend  = 1'b0;
    lift_flag = 1'b0;
    ret_flag  = 1'b0;
    ping_out  = 1'b0;
    led       = 1'b0;
    echo_cnt  = '0;
    raise_lvl = DUTY_OFF;
    lower_lvl = DUTY_OFF;
    wheel_l   = DUTY_OFF;
    wheel_r   = DUTY_OFF;
  endfunction

  function automatic logic [DUTY_BITS-1:0] lane_duty(logic [BASE_BITS-1:0] base,
                                                     logic [GROUP_BITS-1:0] lane);
    logic [SUM_BITS-1:0] total;
    logic [15:0] diff;
    int k;
    total = '0;
    for (k = 0; k < LANE_SAMPLES; k++)
      total += SUM_BITS'(lane[k*SAMPLE_BITS +: SAMPLE_BITS]);
    diff = 16'(base) - 16'(total >> AVG_SHIFT);
    return diff[DUTY_BITS-1:0];
  endfunction

  function automatic lfl_out_t controller_step(lfl_in_t b);
    lfl_out_t r;
    logic due;
    r = '0;
    if (b.button_event) btn_pend = 1'b1;
    if (ctl_mode == MODE_LIFT && b.lift_reed_event) begin
      lift_flag = 1'b1;
      ret_flag  = 1'b0;
    end
    if (ctl_mode == MODE_WAIT && b.return_reed_event) begin
      lift_flag = 1'b0;
      ret_flag  = 1'b1;
    end
    case (ctl_mode)
      MODE_APPROACH: begin
        if (b.magnet_level >= regs.magnet_threshold) ctl_mode = MODE_LIFT;
        if (btn_pend) begin
          btn_pend = 1'b0;
          ctl_mode = MODE_IDLE;
        end
        wheel_l = lane_duty(regs.approach_base, b.left_samples);
        wheel_r = lane_duty(regs.approach_base, b.right_samples);
        led = 1'b0;
      end
      MODE_LIFT: begin
        raise_lvl = DUTY_FULL;
        lower_lvl = DUTY_OFF;
        if (lift_flag) ctl_mode = MODE_WAIT;
        wheel_l = DUTY_OFF;
        wheel_r = DUTY_OFF;
        led = 1'b1;
      end
      MODE_WAIT: begin
        wheel_l = DUTY_OFF;
        wheel_r = DUTY_OFF;
        raise_lvl = DUTY_OFF;
        lower_lvl = DUTY_FULL;
        if (ret_flag) begin
          lower_lvl = DUTY_OFF;
          ctl_mode = MODE_FOLLOW;
        end
      end
      MODE_FOLLOW: begin
        wheel_l = lane_duty(regs.follow_base, b.left_samples);
        wheel_r = lane_duty(regs.follow_base, b.right_samples);
        led = 1'b0;
        due = (echo_cnt == {1'b0, regs.echo_wait});
        if (ping_out) echo_cnt = echo_cnt + 1'b1;
        if (!ping_out) begin
          r.ping_request = 1'b1;
          ping_out = 1'b1;
        end
        if (due) begin
          if (b.range_reading >= regs.range_min && b.range_reading <= regs.range_max) begin
            r.range_valid = 1'b1;
            r.range_out = b.range_reading;
          end
          ping_out = 1'b0;
          echo_cnt = '0;
        end
        if (btn_pend) begin
          btn_pend = 1'b0;
          ctl_mode = MODE_IDLE;
        end
      end
      default: begin
        wheel_l = DUTY_OFF;
        wheel_r = DUTY_OFF;
        led = 1'b1;
        ctl_mode = MODE_IDLE;
        if (btn_pend) begin
          btn_pend = 1'b0;
          ctl_mode = MODE_APPROACH;
        end
      end
    endcase
    r.left_duty = wheel_l;
    r.right_duty = wheel_r;
    r.lift_up_duty = raise_lvl;
    r.lift_down_duty = lower_lvl;
    r.indicator = led;
    r.mode_now = ctl_mode;
    return r;
  endfunction

  function automatic lfl_in_t sensor_beat(logic [GROUP_BITS-1:0] lane_l, lane_r,
                                          logic [MAGNET_BITS-1:0] magnet,
                                          logic btn, up, down,
                                          logic [RANGE_BITS-1:0] reading);
    lfl_in_t b;
    b.left_samples = lane_l;
    b.right_samples = lane_r;
    b.magnet_level = magnet;
    b.button_event = btn;
    b.lift_reed_event = up;
    b.return_reed_event = down;
    b.range_reading = reading;
    return b;
  endfunction

  function automatic logic chance(int unsigned n);
    return $urandom_range(0, n - 1) == 0;
  endfunction

  function automatic lfl_in_t random_beat();
    lfl_in_t b;
    int unsigned pick;
    b.left_samples  = {16'($urandom), $urandom};
    b.right_samples = {16'($urandom), $urandom};
    pick = $urandom_range(0, 9);
    if (pick == 0) b.left_samples = '1;
    else if (pick == 1) b.right_samples = '0;
    b.magnet_level = 12'($urandom);
    if (ctl_mode == MODE_APPROACH) begin
      if (chance(4)) b.magnet_level = 12'($urandom_range(4095, regs.magnet_threshold));
      else if (regs.magnet_threshold != 0)
        b.magnet_level = 12'($urandom_range(0, regs.magnet_threshold - 1'b1));
    end
    b.button_event = chance(ctl_mode == MODE_IDLE ? 3 :
                            ctl_mode == MODE_APPROACH ? 10 :
                            ctl_mode == MODE_FOLLOW ? 25 : 30);
    b.lift_reed_event = chance(ctl_mode == MODE_LIFT ? 3 : 8);
    b.return_reed_event = chance(ctl_mode == MODE_WAIT ? 3 : 8);
    b.range_reading = 16'($urandom);
    if (ctl_mode == MODE_FOLLOW) begin
      pick = $urandom_range(0, 6);
      case (pick)
        0: b.range_reading = regs.range_min - 1'b1;
        1: b.range_reading = regs.range_max + 1'b1;
        2: b.range_reading = regs.range_min;
        3: b.range_reading = regs.range_max;
        4, 5: b.range_reading = 16'($urandom_range(regs.range_max, regs.range_min));
        default: ;
      endcase
    end
    return b;
  endfunction

  task automatic send_beat(input lfl_in_t b);
    sensor_if.payload = b;
    sensor_if.valid = 1'b1;
    do @(posedge clk); while (!sensor_if.ready);
    expected_beats.push_back(controller_step(b));
    @(negedge clk);
    sensor_if.valid = 1'b0;
    if (bursts_on && chance(6)) repeat ($urandom_range(1, 11)) @(negedge clk);
  endtask

  task automatic wait_results_drained();
    while (expected_beats.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input lfl_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_APPROACH_BASE:    regs.approach_base = val[BASE_BITS-1:0];
      REG_FOLLOW_BASE:      regs.follow_base = val[BASE_BITS-1:0];
      REG_MAGNET_THRESHOLD: regs.magnet_threshold = val[MAGNET_BITS-1:0];
      REG_RANGE_MIN:        regs.range_min = val[RANGE_BITS-1:0];
      REG_RANGE_MAX:        regs.range_max = val[RANGE_BITS-1:0];
      REG_ECHO_WAIT:        regs.echo_wait = val[WAIT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input int unsigned ab, fb, thr, rmin, rmax, ew);
    wait_results_drained();
    write_reg(REG_APPROACH_BASE, 16'(ab));
    write_reg(REG_FOLLOW_BASE, 16'(fb));
    write_reg(REG_MAGNET_THRESHOLD, 16'(thr));
    write_reg(REG_RANGE_MIN, 16'(rmin));
    write_reg(REG_RANGE_MAX, 16'(rmax));
    write_reg(REG_ECHO_WAIT, 16'(ew));
  endtask

  // idle -> approach -> lift -> wait -> follow, four beats
  task automatic walk_to_follow();
    send_beat(sensor_beat('0, '0, '0, 1'b1, 1'b0, 1'b0, '0));
    send_beat(sensor_beat('1, '0, '1, 1'b0, 1'b0, 1'b0, '0));
    send_beat(sensor_beat('0, '1, '0, 1'b0, 1'b1, 1'b0, '0));
    send_beat(sensor_beat('0, '0, '0, 1'b0, 1'b0, 1'b1, '0));
  endtask

  task automatic test_mode_walk();
    send_beat(sensor_beat('0, '0, '0, 1'b0, 1'b0, 1'b0, '0));
    send_beat(sensor_beat('1, '1, '1, 1'b0, 1'b1, 1'b1, '1));
    send_beat(sensor_beat('1, '0, 12'd5, 1'b1, 1'b0, 1'b0, 16'd7));
    send_beat(sensor_beat('1, '0, 12'd99, 1'b0, 1'b0, 1'b0, 16'd7));
    send_beat(sensor_beat('0, '1, 12'd4095, 1'b1, 1'b0, 1'b0, 16'd7));
    send_beat(sensor_beat('0, '0, '0, 1'b1, 1'b0, 1'b0, '0));
    send_beat(sensor_beat(48'h123_456_789_ABC, 48'hFED_CBA_987_654, 12'd100,
                          1'b0, 1'b0, 1'b0, '0));
    send_beat(sensor_beat('1, '1, '0, 1'b0, 1'b0, 1'b1, '0));
    send_beat(sensor_beat('1, '1, '0, 1'b0, 1'b1, 1'b0, '0));
    send_beat(sensor_beat('0, '0, '0, 1'b0, 1'b1, 1'b0, '0));
    send_beat(sensor_beat('0, '0, '0, 1'b0, 1'b0, 1'b1, '0));
    repeat (5) send_beat(sensor_beat('1, '0, '0, 1'b0, 1'b0, 1'b0, 16'd20));
    repeat (5) send_beat(sensor_beat('0, '1, '0, 1'b0, 1'b0, 1'b0, 16'd500));
    send_beat(sensor_beat('1, '1, '0, 1'b1, 1'b0, 1'b0, 16'd501));
  endtask

  task automatic test_echo_same_tick();
    load_regs(270, 260, 100, 20, 500, 0);
    walk_to_follow();
    send_beat(sensor_beat('0, '0, '0, 1'b0, 1'b0, 1'b0, 16'd19));
    send_beat(sensor_beat('0, '0, '0, 1'b0, 1'b0, 1'b0, 16'd20));
    send_beat(sensor_beat('0, '0, '0, 1'b0, 1'b0, 1'b0, 16'd500));
    send_beat(sensor_beat('0, '0, '0, 1'b0, 1'b0, 1'b0, 16'd501));
    send_beat(sensor_beat('0, '0, '0, 1'b0, 1'b0, 1'b0, 16'd0));
    send_beat(sensor_beat('0, '0, '0, 1'b1, 1'b0, 1'b0, 16'hFFFF));
  endtask

  // leave follow mid-count, lower the wait below it, and let the count wrap
  task automatic test_echo_overrun();
    load_regs(270, 260, 100, 20, 500, 15);
    walk_to_follow();
    repeat (8) send_beat(sensor_beat('0, '0, '0, 1'b0, 1'b0, 1'b0, 16'd300));
    send_beat(sensor_beat('0, '0, '0, 1'b1, 1'b0, 1'b0, 16'd300));
    wait_results_drained();
    write_reg(REG_ECHO_WAIT, 16'd2);
    walk_to_follow();
    repeat (27) send_beat(sensor_beat('0, '0, '0, 1'b0, 1'b0, 1'b0, 16'd300));
    send_beat(sensor_beat('0, '0, '0, 1'b1, 1'b0, 1'b0, 16'd300));
  endtask

  task automatic test_random_traffic(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      if (i == count / 2 || chance(60)) wait_results_drained();
      send_beat(random_beat());
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, got);
    if (want !== got) begin
      $display("%0t: mismatch on %s, expected %0d, actual %0d", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: mismatch, result beat with none expected, actual %h",
                 $realtime, result_if.payload);
        mismatches++;
      end else begin
        want_beat = expected_beats.pop_front();
        check_field("left_duty", 16'(want_beat.left_duty),
                    16'(result_if.payload.left_duty));
        check_field("right_duty", 16'(want_beat.right_duty),
                    16'(result_if.payload.right_duty));
        check_field("lift_up_duty", 16'(want_beat.lift_up_duty),
                    16'(result_if.payload.lift_up_duty));
        check_field("lift_down_duty", 16'(want_beat.lift_down_duty),
                    16'(result_if.payload.lift_down_duty));
        check_field("indicator", 16'(want_beat.indicator),
                    16'(result_if.payload.indicator));
        check_field("mode_now", 16'(want_beat.mode_now),
                    16'(result_if.payload.mode_now));
        check_field("ping_request", 16'(want_beat.ping_request),
                    16'(result_if.payload.ping_request));
        check_field("range_valid", 16'(want_beat.range_valid),
                    16'(result_if.payload.range_valid));
        check_field("range_out", want_beat.range_out, result_if.payload.range_out);
      end
    end
  end

  initial begin : result_sink
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (bursts_on && chance(10)) begin
        result_if.ready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      result_if.ready = 1'b1;
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((sensor_if.valid && sensor_if.ready) || (result_if.valid && result_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_APPROACH_BASE;
    cfg_data = '0;
    sensor_if.valid = 1'b0;
    sensor_if.payload = '0;
    reset_controller_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_mode_walk();
    test_echo_same_tick();
    test_echo_overrun();
    load_regs(0, 1023, 0, 0, 65535, 0);
    test_random_traffic(110);
    load_regs(1023, 0, 4095, 1000, 60000, 15);
    test_random_traffic(110);
    load_regs($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 4095),
              100, 100 + $urandom_range(0, 5000), $urandom_range(0, 15));
    test_random_traffic(110);
    load_regs($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 4095),
              600, 599, $urandom_range(0, 15));
    test_random_traffic(100);
    load_regs($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 4095),
              $urandom_range(0, 50), $urandom_range(2000, 65535), $urandom_range(0, 15));
    bursts_on = 1'b0;
    test_random_traffic(100);

    wait_results_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
